FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker modules of this block.
// Both macros expect signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BTBB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never hold at a clock edge.
`define BTBB_NEVER(label, expr, msg) \
    `BTBB_ASSERT(label, !(expr), msg)

`endif

FILE: hw/rtl/btbb_pkg.sv
package btbb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

    localparam int PIX_W  = 8;
    localparam int NCH    = 3;
    localparam int WORD_W = PIX_W * (NCH + 1);
    localparam int POS_W  = 8;
    localparam int DIM_W  = 9;
    localparam int STR_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [STR_W-1:0] STR_MAX = STR_W'(100);
    localparam int RAD_STEP = 20;
    localparam int MAX_RAD  = 100 / RAD_STEP;
    localparam int RAD_W    = $clog2(MAX_RAD + 1);

    // Window sums and pixel counts for a window of at most (2*MAX_RAD+1)^2 pixels.
    localparam int MAX_CNT = (2 * MAX_RAD + 1) * (2 * MAX_RAD + 1);
    localparam int CNT_W   = $clog2(MAX_CNT + 1);
    localparam int SUM_W   = $clog2(MAX_CNT * 255 + 1);
    localparam int STEP_W  = $clog2(SUM_W);

    // (255 - c) * s and 255 * s, both at most 25500.
    localparam int PROD_W = PIX_W + STR_W;
    // floor(n / 100) == (n * 5243) >> 19 for every n below 43699.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int DIV100_W     = PROD_W + 13;

    localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(255);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = CFG_IDX_W'(2);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [SUM_W-1:0] sum_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LD_MUL,
        ST_LD_WR,
        ST_FE_SETUP,
        ST_FE_READ,
        ST_FE_DRAIN,
        ST_FE_DIVGO,
        ST_FE_DIV
    } state_t;

    function automatic logic [STR_W-1:0] eff_strength(input logic [STR_W-1:0] s);
        return (s > STR_MAX) ? STR_MAX : s;
    endfunction

    // Blur radius is floor(s / 20), found by comparing against the step multiples.
    function automatic logic [RAD_W-1:0] radius_of(input logic [STR_W-1:0] s);
        logic [RAD_W-1:0] r;
        r = '0;
        for (int k = 1; k <= MAX_RAD; k++) begin
            if (s >= STR_W'(k * RAD_STEP)) begin
                r = RAD_W'(k);
            end
        end
        return r;
    endfunction

    function automatic pix_t div100(input logic [PROD_W-1:0] n);
        logic [DIV100_W-1:0] p;
        p = DIV100_W'(n) * DIV100_W'(DIV100_MUL);
        return p[DIV100_SHIFT +: PIX_W];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end
        else if (v > hi) begin
            r = hi;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/btbb_div.sv
// Restoring divider, one quotient bit per cycle for all colour lanes at once.
module btbb_div
    import btbb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  sum_t [NCH-1:0]      dividend,
    input  logic [CNT_W-1:0]    divisor,
    output logic                done,
    output pix_t [NCH-1:0]      quotient
);

    sum_t [NCH-1:0]             num_reg, num_next;
    logic [NCH-1:0][CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]           div_reg, div_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [CNT_W:0]             rem_sh;
    logic                       fits;

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = '0;
        fits      = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter at the bottom.
            for (int i = 0; i < NCH; i++)
            begin
                rem_sh      = {rem_reg[i], num_reg[i][SUM_W-1]};
                fits        = (rem_sh >= {1'b0, div_reg});
                rem_next[i] = fits ? CNT_W'(rem_sh - {1'b0, div_reg}) : CNT_W'(rem_sh);
                num_next[i] = {num_reg[i][SUM_W-2:0], fits};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            quotient[i] = num_reg[i][PIX_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

FILE: hw/rtl/bloom_threshold_box_blur.sv
// Threshold bloom with a box blur over a 256 x 256 RGBA frame store.
//
// Commands enter on start with func, pos_x, pos_y and the pixel fields; a
// transaction is taken at a clock edge where start is high and busy is low.
// A load (func 0) brightens the pixel when any colour channel is above the
// strength threshold and writes it into the frame store. It produces no
// result and keeps busy high through its multiply and write states.
// A fetch (func 1) reads the clipped square window around (pos_x, pos_y) from
// the store, one pixel per cycle through the single memory port, and divides
// the three channel sums by the pixel count in a serial divider.
// The clipped window holds from 1 to 121 pixels. A fetch outside the frame
// returns all zeros without reading the store.
// Each result is shown on out_red/out_green/out_blue/out_alpha for exactly one
// cycle with result_valid high; the receiver cannot hold it off. busy falls
// in that same cycle, so the next command may be taken while the result shows.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is low while a command is in progress or while start is high, so
// a register never changes under a command. Reset returns the control to idle
// and the registers to strength 0 and a 256 x 256 frame; the frame store
// itself is not cleared and holds whatever was loaded before.
module bloom_threshold_box_blur
    import btbb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic [PIX_W-1:0]      alpha,
    output logic                  result_valid,
    output logic [PIX_W-1:0]      out_red,
    output logic [PIX_W-1:0]      out_green,
    output logic [PIX_W-1:0]      out_blue,
    output logic [PIX_W-1:0]      out_alpha,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Frame store: one 32-bit RGBA word per pixel, addressed {row, column}.
    logic [WORD_W-1:0] frame_mem [MEM_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [2*POS_W-1:0] mem_addr;
    logic               mem_we;
    logic               mem_re;
    logic [WORD_W-1:0]  mem_wdata;

    // Configuration registers.
    logic [STR_W-1:0] strength_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // Control state.
    state_t state_reg, state_next;
    logic   rd_pend_reg, rd_pend_next;
    logic   result_valid_reg, result_valid_next;

    // Command and datapath registers.
    logic [POS_W-1:0]            x_reg, x_next;
    logic [POS_W-1:0]            y_reg, y_next;
    pix_t [NCH-1:0]              pix_reg, pix_next;
    pix_t                        alpha_in_reg, alpha_in_next;
    logic [NCH-1:0][PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]           thr_prod_reg, thr_prod_next;
    logic [POS_W-1:0]            xx_reg, xx_next;
    logic [POS_W-1:0]            yy_reg, yy_next;
    logic [POS_W-1:0]            x0_reg, x0_next;
    logic [POS_W-1:0]            x1_reg, x1_next;
    logic [POS_W-1:0]            y1_reg, y1_next;
    sum_t [NCH-1:0]              sum_reg, sum_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        rd_centre_reg, rd_centre_next;
    pix_t                        cen_alpha_reg, cen_alpha_next;
    pix_t [NCH-1:0]              out_rgb_reg, out_rgb_next;
    pix_t                        out_alpha_reg, out_alpha_next;

    // Combinational helpers.
    logic [STR_W-1:0] s_eff;
    logic [RAD_W-1:0] rad;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] x_hi;
    logic [DIM_W-1:0] y_hi;
    pix_t             thr;
    logic             hot;
    pix_t             chan;

    // Divider link.
    logic           div_start;
    logic           div_done;
    pix_t [NCH-1:0] div_quot;

    assign s_eff = eff_strength(strength_reg);
    assign rad   = radius_of(s_eff);
    assign w_eff = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));
    assign x_hi  = {1'b0, x_reg} + DIM_W'(rad);
    assign y_hi  = {1'b0, y_reg} + DIM_W'(rad);

    btbb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next        = state_reg;
        rd_pend_next      = 1'b0;
        rd_centre_next    = 1'b0;
        result_valid_next = 1'b0;
        x_next            = x_reg;
        y_next            = y_reg;
        pix_next          = pix_reg;
        alpha_in_next     = alpha_in_reg;
        prod_next         = prod_reg;
        thr_prod_next     = thr_prod_reg;
        xx_next           = xx_reg;
        yy_next           = yy_reg;
        x0_next           = x0_reg;
        x1_next           = x1_reg;
        y1_next           = y1_reg;
        sum_next          = sum_reg;
        cnt_next          = cnt_reg;
        cen_alpha_next    = cen_alpha_reg;
        out_rgb_next      = out_rgb_reg;
        out_alpha_next    = out_alpha_reg;
        mem_addr          = {yy_reg, xx_reg};
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_wdata         = '0;
        div_start         = 1'b0;
        thr               = '0;
        hot               = 1'b0;
        chan              = '0;

        // Read data is registered, so it arrives in the cycle after its read; fold it into the sums.
        if (rd_pend_reg)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                sum_next[i] = sum_reg[i] + SUM_W'(rd_data_reg[i*PIX_W +: PIX_W]);
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (rd_centre_reg)
            begin
                cen_alpha_next = rd_data_reg[NCH*PIX_W +: PIX_W];
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x_next        = pos_x;
                    y_next        = pos_y;
                    pix_next      = {blue, green, red};
                    alpha_in_next = alpha;
                    state_next    = (func == FUNC_LOAD) ? ST_LD_MUL : ST_FE_SETUP;
                end
            end
            ST_LD_MUL:
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    prod_next[i] = PROD_W'(PIX_MAX - pix_reg[i]) * PROD_W'(s_eff);
                end
                thr_prod_next = PROD_W'(PIX_MAX) * PROD_W'(s_eff);
                state_next    = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                thr = div100(thr_prod_reg);
                for (int i = 0; i < NCH; i++)
                begin
                    if (pix_reg[i] > thr)
                    begin
                        hot = 1'b1;
                    end
                end
                for (int i = 0; i < NCH; i++)
                begin
                    chan = hot ? pix_reg[i] + div100(prod_reg[i]) : pix_reg[i];
                    mem_wdata[i*PIX_W +: PIX_W] = chan;
                end
                mem_wdata[NCH*PIX_W +: PIX_W] = alpha_in_reg;
                mem_addr   = {y_reg, x_reg};
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FE_SETUP:
            begin
                sum_next = '0;
                cnt_next = '0;
                if (({1'b0, x_reg} >= w_eff) || ({1'b0, y_reg} >= h_eff))
                begin
                    out_rgb_next      = '0;
                    out_alpha_next    = '0;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    x0_next    = (x_reg >= POS_W'(rad)) ? x_reg - POS_W'(rad) : '0;
                    yy_next    = (y_reg >= POS_W'(rad)) ? y_reg - POS_W'(rad) : '0;
                    xx_next    = (x_reg >= POS_W'(rad)) ? x_reg - POS_W'(rad) : '0;
                    x1_next    = (x_hi < w_eff) ? x_hi[POS_W-1:0]
                                                : POS_W'(w_eff - DIM_W'(1));
                    y1_next    = (y_hi < h_eff) ? y_hi[POS_W-1:0]
                                                : POS_W'(h_eff - DIM_W'(1));
                    state_next = ST_FE_READ;
                end
            end
            ST_FE_READ:
            begin
                mem_addr       = {yy_reg, xx_reg};
                mem_re         = 1'b1;
                rd_pend_next   = 1'b1;
                rd_centre_next = (xx_reg == x_reg) && (yy_reg == y_reg);
                if (xx_reg == x1_reg)
                begin
                    xx_next = x0_reg;
                    if (yy_reg == y1_reg)
                    begin
                        state_next = ST_FE_DRAIN;
                    end
                    else
                    begin
                        yy_next = yy_reg + POS_W'(1);
                    end
                end
                else
                begin
                    xx_next = xx_reg + POS_W'(1);
                end
            end
            ST_FE_DRAIN:
            begin
                // The last window pixel is being added this cycle.
                state_next = ST_FE_DIVGO;
            end
            ST_FE_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_FE_DIV;
            end
            ST_FE_DIV:
            begin
                if (div_done)
                begin
                    out_rgb_next      = div_quot;
                    out_alpha_next    = cen_alpha_reg;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rd_pend_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rd_pend_reg      <= rd_pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strength_reg <= '0;
            width_reg    <= DIM_W'(MAX_WIDTH);
            height_reg   <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                CFG_STRENGTH: strength_reg <= cfg_data[STR_W-1:0];
                CFG_WIDTH:    width_reg    <= cfg_data[DIM_W-1:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[DIM_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        x_next_hold: begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            pix_reg       <= pix_next;
            alpha_in_reg  <= alpha_in_next;
            prod_reg      <= prod_next;
            thr_prod_reg  <= thr_prod_next;
            xx_reg        <= xx_next;
            yy_reg        <= yy_next;
            x0_reg        <= x0_next;
            x1_reg        <= x1_next;
            y1_reg        <= y1_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            rd_centre_reg <= rd_centre_next;
            cen_alpha_reg <= cen_alpha_next;
            out_rgb_reg   <= out_rgb_next;
            out_alpha_reg <= out_alpha_next;
        end
    end

    // Single-port store with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        else if (mem_re)
        begin
            rd_data_reg <= frame_mem[mem_addr];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    // A command taken at this edge uses the registers as they are now.
    assign cfg_ready    = (state_reg == ST_IDLE) && !start;
    assign result_valid = result_valid_reg;
    assign out_red      = out_rgb_reg[0];
    assign out_green    = out_rgb_reg[1];
    assign out_blue     = out_rgb_reg[2];
    assign out_alpha    = out_alpha_reg;

endmodule

FILE: hw/rtl/btbb_checker.sv
`include "assert_macros.svh"

// Port-level checks on command and result timing.
module btbb_checker
    import btbb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic func,
    input logic result_valid
);

    `BTBB_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction did not raise busy")
    `BTBB_ASSERT(a_result_pulse, result_valid |=> !result_valid, "result strobe longer than one cycle")
    `BTBB_ASSERT(a_load_silent, (start && !busy && func == FUNC_LOAD) |=> !result_valid ##1 !result_valid, "load produced a result")
    `BTBB_NEVER(a_result_unasked, result_valid && !$past(busy), "result without a transaction in progress")

endmodule

bind bloom_threshold_box_blur btbb_checker u_btbb_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .result_valid (result_valid)
);

FILE: bench/bloom_threshold_box_blur_tb.sv
module bloom_threshold_box_blur_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import btbb_pkg::*;

    // Clock, reset and run-length settings.
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    // The slowest fetch, a sender gap and a pause between phases together stay
    // below this limit, so a quiet stretch this long means a hang.
    localparam int WATCHDOG_LIMIT = 1000;
    // A load keeps the block busy after its transaction; this pause lets it finish.
    localparam int PHASE_PAUSE    = 8;
    // Long enough for a stray result of the largest window to show up.
    localparam int DRAIN_CYCLES   = 160;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 75;
    // The sender idles at most this long between bursts.
    localparam int MAX_GAP        = 15;
    localparam int MAX_BURST      = 40;
    // Corner hot spots are this many pixels wide on each side of the frame.
    localparam int CORNER_SPAN    = 3;

    // The fourth register index decodes to nothing; writes to it must be harmless.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    // One command as it is presented on the input ports.
    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        pix_t             r;
        pix_t             g;
        pix_t             b;
        pix_t             a;
    } command_t;

    // One blurred pixel as it leaves the block.
    typedef struct packed {
        pix_t r;
        pix_t g;
        pix_t b;
        pix_t a;
    } blur_pixel_t;

    // Register values written at the start of one random phase.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] strength;
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
    } phase_cfg_t;

    // Every input starts at a known value so nothing is X before reset ends.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  func      = FUNC_LOAD;
    logic [POS_W-1:0]      pos_x     = '0;
    logic [POS_W-1:0]      pos_y     = '0;
    pix_t                  red       = '0;
    pix_t                  green     = '0;
    pix_t                  blue      = '0;
    pix_t                  alpha     = '0;
    logic                  result_valid;
    pix_t                  out_red;
    pix_t                  out_green;
    pix_t                  out_blue;
    pix_t                  out_alpha;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Our own copy of the frame store and of the three registers. The copy of
    // the registers is updated when a register write transaction completes.
    bit [WORD_W-1:0]       frame_model [MEM_DEPTH];
    // Entries that some queued load has written. A fetch is only queued once
    // its whole clipped window is covered, since unwritten entries are
    // undefined in the hardware.
    bit                    pixel_loaded [MEM_DEPTH];
    logic [STR_W-1:0]      strength_reg = '0;
    logic [DIM_W-1:0]      width_reg    = DIM_W'(MAX_WIDTH);
    logic [DIM_W-1:0]      height_reg   = DIM_W'(MAX_HEIGHT);

    command_t              pending_cmds[$];
    blur_pixel_t           blur_expected[$];
    command_t              next_cmd;
    blur_pixel_t           blur_seen;
    int                    queued_items   = 0;
    int                    accepted_items = 0;
    int                    error_count    = 0;
    int                    idle_cycles    = 0;
    int                    burst_left     = 0;
    int                    gap_left       = 0;

    bloom_threshold_box_blur dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .result_valid (result_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Strength in use: anything above 100 percent saturates.
    function automatic int active_strength();
        return (strength_reg > 7'd100) ? 100 : int'(strength_reg);
    endfunction

    // Frame dimension in use: zero reads as one, and it never exceeds the store.
    function automatic int active_dim(input logic [DIM_W-1:0] v, input int limit);
        int d;
        d = int'(v);
        if (d < 1)
        begin
            d = 1;
        end
        else if (d > limit)
        begin
            d = limit;
        end
        return d;
    endfunction

    function automatic int brighten(input int c, input int s);
        return c + ((255 - c) * s) / 100;
    endfunction

    // Applies one accepted command to the frame copy. A load updates the store
    // and yields nothing; a fetch yields the clipped box mean plus the alpha of
    // its centre, or all zeros when the position lies outside the frame.
    // Positions are 8 bits wide, so a load can never fall beyond the store.
    function automatic void bloom_blur_step(input command_t c);
        int          s;
        int          thr;
        int          r;
        int          g;
        int          b;
        int          x;
        int          y;
        int          w;
        int          h;
        int          rad;
        int          x0;
        int          x1;
        int          y0;
        int          y1;
        int          sum_r;
        int          sum_g;
        int          sum_b;
        int          count;
        bit [WORD_W-1:0] word;
        blur_pixel_t res;
        s = active_strength();
        x = int'(c.x);
        y = int'(c.y);
        if (c.func == FUNC_LOAD)
        begin
            thr = (255 * s) / 100;
            r = int'(c.r);
            g = int'(c.g);
            b = int'(c.b);
            if (r > thr || g > thr || b > thr)
            begin
                r = brighten(r, s);
                g = brighten(g, s);
                b = brighten(b, s);
            end
            frame_model[y * MAX_WIDTH + x] = {c.a, pix_t'(b), pix_t'(g), pix_t'(r)};
        end
        else
        begin
            w = active_dim(width_reg, MAX_WIDTH);
            h = active_dim(height_reg, MAX_HEIGHT);
            res = '0;
            if (x < w && y < h)
            begin
                rad   = s / 20;
                x0    = (x >= rad) ? x - rad : 0;
                y0    = (y >= rad) ? y - rad : 0;
                x1    = (x + rad < w) ? x + rad : w - 1;
                y1    = (y + rad < h) ? y + rad : h - 1;
                sum_r = 0;
                sum_g = 0;
                sum_b = 0;
                count = 0;
                for (int yy = y0; yy <= y1; yy++)
                begin
                    for (int xx = x0; xx <= x1; xx++)
                    begin
                        word  = frame_model[yy * MAX_WIDTH + xx];
                        sum_r += int'(word[7:0]);
                        sum_g += int'(word[15:8]);
                        sum_b += int'(word[23:16]);
                        count++;
                    end
                end
                res.r = pix_t'(sum_r / count);
                res.g = pix_t'(sum_g / count);
                res.b = pix_t'(sum_b / count);
                res.a = frame_model[y * MAX_WIDTH + x][31:24];
            end
            blur_expected.push_back(res);
        end
    endfunction

    // Channel values cluster on the extremes and on both sides of the bloom
    // threshold, so the brighten decision is hit from both directions.
    function automatic int pick_channel();
        int thr;
        int v;
        thr = (255 * active_strength()) / 100;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 255;
            2:       v = thr;
            3:       v = (thr < 255) ? thr + 1 : 255;
            default: v = $urandom_range(0, 255);
        endcase
        return v;
    endfunction

    function automatic void queue_load(input int x, input int y, input int r, input int g,
                                       input int b, input int a);
        command_t c;
        c.func = FUNC_LOAD;
        c.x    = POS_W'(x);
        c.y    = POS_W'(y);
        c.r    = pix_t'(r);
        c.g    = pix_t'(g);
        c.b    = pix_t'(b);
        c.a    = pix_t'(a);
        pending_cmds.push_back(c);
        pixel_loaded[y * MAX_WIDTH + x] = 1'b1;
        queued_items++;
    endfunction

    function automatic void queue_random_load(input int x, input int y);
        queue_load(x, y, pick_channel(), pick_channel(), pick_channel(), $urandom_range(0, 255));
    endfunction

    // Queues a fetch, first loading any pixel of its clipped window that has
    // never been written. The pixel fields of a fetch are ignored by the block,
    // so they carry random values.
    function automatic void queue_fetch(input int x, input int y);
        int       w;
        int       h;
        int       rad;
        int       x0;
        int       x1;
        int       y0;
        int       y1;
        command_t c;
        w = active_dim(width_reg, MAX_WIDTH);
        h = active_dim(height_reg, MAX_HEIGHT);
        if (x < w && y < h)
        begin
            rad = active_strength() / 20;
            x0  = (x >= rad) ? x - rad : 0;
            y0  = (y >= rad) ? y - rad : 0;
            x1  = (x + rad < w) ? x + rad : w - 1;
            y1  = (y + rad < h) ? y + rad : h - 1;
            for (int yy = y0; yy <= y1; yy++)
            begin
                for (int xx = x0; xx <= x1; xx++)
                begin
                    if (!pixel_loaded[yy * MAX_WIDTH + xx])
                    begin
                        queue_random_load(xx, yy);
                    end
                end
            end
        end
        c.func = FUNC_FETCH;
        c.x    = POS_W'(x);
        c.y    = POS_W'(y);
        c.r    = pix_t'($urandom_range(0, 255));
        c.g    = pix_t'($urandom_range(0, 255));
        c.b    = pix_t'($urandom_range(0, 255));
        c.a    = pix_t'($urandom_range(0, 255));
        pending_cmds.push_back(c);
        queued_items++;
    endfunction

    // A coordinate near the low or the high edge of a frame dimension, where
    // window clipping happens and where earlier loads are reused.
    function automatic int pick_corner(input int dim);
        int span;
        span = (dim > CORNER_SPAN) ? CORNER_SPAN : dim;
        if ($urandom_range(0, 1) == 0)
        begin
            return $urandom_range(0, span - 1);
        end
        return dim - 1 - int'($urandom_range(0, span - 1));
    endfunction

    // Register settings of the random phases. The fixed ones reach the
    // extremes, including values that must saturate or clamp.
    function automatic phase_cfg_t phase_plan(input int p);
        phase_cfg_t pc;
        case (p)
            0:       pc = '{9'd100, 9'd256, 9'd256};
            1:       pc = '{9'd0,   9'd1,   9'd1};
            2:       pc = '{9'd20,  9'd9,   9'd256};
            3:       pc = '{9'd127, 9'd0,   9'd5};
            4:       pc = '{9'd99,  9'd300, 9'd511};
            6:       pc = '{9'd40,  9'd256, 9'd3};
            7:       pc = '{9'd60,  9'd17,  9'd0};
            8:       pc = '{9'd80,  9'd2,   9'd12};
            default: pc = '{CFG_DATA_W'($urandom_range(0, 127)),
                            CFG_DATA_W'($urandom_range(1, 24)),
                            CFG_DATA_W'($urandom_range(1, 24))};
        endcase
        return pc;
    endfunction

    // One register write transaction. Our copy of the register changes at the
    // edge where valid and ready are both high.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STRENGTH: strength_reg = data[STR_W-1:0];
            CFG_WIDTH:    width_reg    = data;
            CFG_HEIGHT:   height_reg   = data;
            default:      ;
        endcase
    endtask

    // Waits until every queued command has been taken and every fetch has
    // delivered its result, then lets a trailing load finish.
    task automatic wait_idle();
        while (accepted_items != queued_items || blur_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PHASE_PAUSE) @(posedge clk);
    endtask

    // Command driver. A transaction completes at an edge where start is high
    // and busy is low; the predictor sees the command at that same edge, so
    // its expectation is queued before the result can appear. The sender works
    // in bursts of random length separated by random gaps. The gap counter runs
    // every cycle, so start may rise early in a fetch, late in it, or well after
    // busy has fallen. A quarter of the gaps are empty, giving stretches where
    // commands follow each other back to back.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                bloom_blur_step({func, pos_x, pos_y, red, green, blue, alpha});
                accepted_items++;
            end
            if (gap_left != 0)
            begin
                gap_left--;
            end
            if (!start || !busy)
            begin
                if (gap_left == 0 && pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    func  <= next_cmd.func;
                    pos_x <= next_cmd.x;
                    pos_y <= next_cmd.y;
                    red   <= next_cmd.r;
                    green <= next_cmd.g;
                    blue  <= next_cmd.b;
                    alpha <= next_cmd.a;
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, MAX_BURST);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input pix_t want, input pix_t got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result monitor. Each result is shown for exactly one cycle and cannot be
    // held off, so it is taken at the edge that closes that cycle and compared
    // with the oldest outstanding fetch.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
        begin
            if (blur_expected.size() == 0)
            begin
                $error("result with no fetch outstanding: %0d %0d %0d %0d",
                       out_red, out_green, out_blue, out_alpha);
                error_count++;
            end
            else
            begin
                blur_seen = blur_expected.pop_front();
                check_field("out_red", blur_seen.r, out_red);
                check_field("out_green", blur_seen.g, out_green);
                check_field("out_blue", blur_seen.b, out_blue);
                check_field("out_alpha", blur_seen.a, out_alpha);
            end
        end
    end

    // Watchdog: any completed transaction on any port restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid === 1'b1 || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bloom_threshold_box_blur test failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus. A short directed part runs first under three register
    // settings, then the random phases each program all three registers and
    // queue a mix of fetches and loads, mostly around the corners of the frame.
    initial
    begin
        phase_cfg_t pc;
        int         w;
        int         h;
        int         roll;
        int         phase_end;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: strength 0, so any nonzero channel is above the
        // threshold yet brightening adds nothing; radius 0 returns the pixel.
        queue_load(0, 0, 0, 0, 0, 0);
        queue_load(255, 255, 255, 255, 255, 255);
        queue_load(1, 0, 1, 0, 0, 128);
        queue_fetch(0, 0);
        queue_fetch(255, 255);
        queue_fetch(1, 0);
        wait_idle();

        // A strength write with the upper bits set saturates to 100, a zero
        // width reads as one column and an oversized height as the full store.
        // At full strength the threshold is 255, so no pixel brightens.
        write_cfg(CFG_STRENGTH, 9'h1FF);
        write_cfg(CFG_WIDTH, 9'h000);
        write_cfg(CFG_HEIGHT, 9'h1FF);
        queue_load(0, 0, 255, 0, 0, 7);
        // Stored even though it lies outside the one-column frame.
        queue_load(200, 3, 17, 34, 51, 68);
        queue_fetch(0, 0);
        queue_fetch(1, 0);
        queue_fetch(255, 255);
        queue_fetch(0, 255);
        wait_idle();

        // Half strength: threshold 127, radius 2, a tiny frame that clips the
        // window on every side, and a write to the unused register index.
        write_cfg(CFG_SPARE, 9'h0AA);
        write_cfg(CFG_STRENGTH, 9'd50);
        write_cfg(CFG_WIDTH, 9'd2);
        write_cfg(CFG_HEIGHT, 9'd3);
        queue_load(1, 1, 127, 127, 127, 9);
        queue_load(1, 2, 128, 0, 0, 200);
        queue_fetch(1, 1);
        queue_fetch(2, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            pc = phase_plan(p);
            write_cfg(CFG_STRENGTH, pc.strength);
            write_cfg(CFG_WIDTH, pc.width);
            write_cfg(CFG_HEIGHT, pc.height);
            w = active_dim(width_reg, MAX_WIDTH);
            h = active_dim(height_reg, MAX_HEIGHT);
            phase_end = queued_items + PHASE_ITEMS;
            while (queued_items < phase_end)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12 && (w < MAX_WIDTH || h < MAX_HEIGHT))
                begin
                    // Fetch outside the frame: the result is all zeros.
                    if (w < MAX_WIDTH)
                    begin
                        queue_fetch($urandom_range(w, 255), $urandom_range(0, 255));
                    end
                    else
                    begin
                        queue_fetch($urandom_range(0, 255), $urandom_range(h, 255));
                    end
                end
                else if (roll < 60)
                begin
                    if (w * h <= 400 && roll % 2 == 0)
                    begin
                        queue_fetch($urandom_range(0, w - 1), $urandom_range(0, h - 1));
                    end
                    else
                    begin
                        queue_fetch(pick_corner(w), pick_corner(h));
                    end
                end
                else if (roll < 88)
                begin
                    queue_random_load(pick_corner(w), pick_corner(h));
                end
                else
                begin
                    // Anywhere in the store, mostly outside the current frame when it is small.
                    queue_random_load($urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("bloom_threshold_box_blur test passed");
        end
        else
        begin
            $display("bloom_threshold_box_blur test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/btbb_pkg.sv
hw/rtl/btbb_div.sv
hw/rtl/bloom_threshold_box_blur.sv
hw/rtl/btbb_checker.sv
bench/bloom_threshold_box_blur_tb.sv
